// ===== sv/vfmac_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and lane selection helper for the vector fractional mac unit
// no dependencies
package vfmac_pkg;

  localparam int LANE_COUNT_DEF = 8;
  localparam int ACC_BITS_DEF   = 48;
  localparam int PACK_LANES     = 8;
  localparam int ELEM_BITS      = 16;
  localparam int LANE_IDX_BITS  = 4;
  localparam int SEL_BITS       = 4;

  localparam logic [ELEM_BITS-1:0] SAT_MAX = 16'h7fff;
  localparam logic [ELEM_BITS-1:0] SAT_MIN = 16'h8000;

  typedef enum logic {
    OP_MAC = 1'b0,
    OP_ADD = 1'b1
  } op_t;

  typedef struct packed {
    logic load;
    op_t  op;
  } ctl_t;

  typedef logic [ELEM_BITS-1:0] elem_t;

  // source lane of the second operand for destination lane idx
  function automatic logic [LANE_IDX_BITS-1:0] select_lane(
    input logic [LANE_IDX_BITS-1:0] idx,
    input logic [SEL_BITS-1:0]      sel
  );
    logic [LANE_IDX_BITS-1:0] src;
    if (sel < 4'd2) begin
      src = idx;
    end else if (sel < 4'd4) begin
      src = {idx[3:1], sel[0]};
    end else if (sel < 4'd8) begin
      src = {idx[3:2], sel[1:0]};
    end else begin
      src = {1'b0, sel[2:0]};
    end
    return src;
  endfunction

endpackage

// ===== sv/vector_frac_mac_unit.sv =====
`timescale 1ns / 1ps
// Eight-lane 16-bit fractional multiply-accumulate unit with one accumulator per lane.
// Takes one transaction per cycle while in_stall is low. Each result is held first in the lane
// accumulators, which the per-lane multiply-accumulate updates as the transaction is accepted,
// and then in the merge stage, which saturates and registers the packed result in the output
// register. A result transaction may wait on out_stall while the next input is taken; input
// stalls only when the merge slot is occupied and the output register is occupied and stalled.
// Depends on vfmac_pkg, vfmac_sel, vfmac_lane and vfmac_merge.
module vector_frac_mac_unit #(
  parameter int LANE_COUNT       = vfmac_pkg::LANE_COUNT_DEF,
  parameter int ACCUMULATOR_BITS = vfmac_pkg::ACC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_opcode,
  input  logic [63:0]                    in_source_lo,
  input  logic [63:0]                    in_source_hi,
  input  logic [63:0]                    in_other_lo,
  input  logic [63:0]                    in_other_hi,
  input  logic [vfmac_pkg::SEL_BITS-1:0] in_element_select,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [63:0]                    out_result_lo,
  output logic [63:0]                    out_result_hi
);
  import vfmac_pkg::*;

  logic                        accept;
  logic                        out_free;
  logic                        p_valid_r;
  logic                        p_valid_nxt;
  op_t                         p_op_r;
  op_t                         in_op;
  ctl_t                        merge_ctl;
  elem_t                       src_elem [PACK_LANES];
  elem_t                       lane_a   [LANE_COUNT];
  elem_t                       lane_b   [LANE_COUNT];
  logic [ACCUMULATOR_BITS-1:0] lane_acc [LANE_COUNT];

  assign in_op       = op_t'(in_opcode);
  assign out_free    = !out_valid || !out_stall;
  assign in_stall    = p_valid_r && !out_free;
  assign accept      = in_valid && !in_stall;
  assign p_valid_nxt = accept || (p_valid_r && !out_free);

  assign merge_ctl.load = p_valid_r && out_free;
  assign merge_ctl.op   = p_op_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else begin
      p_valid_r <= p_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_op_r <= in_op;
    end
  end

  genvar k;
  generate
    for (k = 0; k < PACK_LANES / 2; k++) begin : g_unpack
      assign src_elem[k]                  = in_source_lo[ELEM_BITS*k +: ELEM_BITS];
      assign src_elem[k + PACK_LANES / 2] = in_source_hi[ELEM_BITS*k +: ELEM_BITS];
    end

    for (k = 0; k < LANE_COUNT; k++) begin : g_lane
      if (k < PACK_LANES) begin : g_packed
        assign lane_a[k] = src_elem[k];
      end else begin : g_extra
        assign lane_a[k] = '0;
      end

      vfmac_lane #(
        .ACCUMULATOR_BITS(ACCUMULATOR_BITS)
      ) u_lane (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (accept),
        .op   (in_op),
        .a    (lane_a[k]),
        .b    (lane_b[k]),
        .acc  (lane_acc[k])
      );
    end
  endgenerate

  vfmac_sel #(
    .LANE_COUNT(LANE_COUNT)
  ) u_sel (
    .other_lo      (in_other_lo),
    .other_hi      (in_other_hi),
    .element_select(in_element_select),
    .lane_b        (lane_b)
  );

  vfmac_merge #(
    .LANE_COUNT      (LANE_COUNT),
    .ACCUMULATOR_BITS(ACCUMULATOR_BITS)
  ) u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (merge_ctl),
    .lane_acc     (lane_acc),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_result_lo(out_result_lo),
    .out_result_hi(out_result_hi)
  );

endmodule

// ===== sv/vfmac_sel.sv =====
`timescale 1ns / 1ps
// element selector: broadcasts the second operand lanes per element_select
// depends on vfmac_pkg
module vfmac_sel #(
  parameter int LANE_COUNT = vfmac_pkg::LANE_COUNT_DEF
) (
  input  logic [63:0]                   other_lo,
  input  logic [63:0]                   other_hi,
  input  logic [vfmac_pkg::SEL_BITS-1:0] element_select,
  output vfmac_pkg::elem_t              lane_b [LANE_COUNT]
);
  import vfmac_pkg::*;

  elem_t other_elem [PACK_LANES];

  genvar k;
  generate
    for (k = 0; k < PACK_LANES / 2; k++) begin : g_unpack
      assign other_elem[k]                  = other_lo[ELEM_BITS*k +: ELEM_BITS];
      assign other_elem[k + PACK_LANES / 2] = other_hi[ELEM_BITS*k +: ELEM_BITS];
    end

    for (k = 0; k < LANE_COUNT; k++) begin : g_lane
      logic [LANE_IDX_BITS-1:0] src;
      assign src = select_lane(LANE_IDX_BITS'(k), element_select);
      always_comb begin
        if (int'(src) < LANE_COUNT && int'(src) < PACK_LANES) begin
          lane_b[k] = other_elem[src[2:0]];
        end else begin
          lane_b[k] = '0;
        end
      end
    end
  endgenerate

endmodule

// ===== sv/vfmac_lane.sv =====
`timescale 1ns / 1ps
// one lane: 16x16 signed multiply with doubling into a wrapping accumulator;
// OP_ADD writes a + b to its low 16 bits; depends on vfmac_pkg
module vfmac_lane #(
  parameter int ACCUMULATOR_BITS = vfmac_pkg::ACC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  vfmac_pkg::op_t              op,
  input  vfmac_pkg::elem_t            a,
  input  vfmac_pkg::elem_t            b,
  output logic [ACCUMULATOR_BITS-1:0] acc
);
  import vfmac_pkg::*;

  logic [ACCUMULATOR_BITS-1:0] acc_r;
  logic [ACCUMULATOR_BITS-1:0] acc_nxt;
  logic signed [31:0]          prod;
  logic signed [32:0]          dbl;
  logic [ACCUMULATOR_BITS-1:0] delta;
  elem_t                       sum;

  assign prod  = $signed(a) * $signed(b);
  assign dbl   = {prod, 1'b0};
  assign delta = {{(ACCUMULATOR_BITS-33){dbl[32]}}, dbl};
  assign sum   = a + b;

  always_comb begin
    acc_nxt = acc_r;
    if (en) begin
      unique case (op)
        OP_MAC:  acc_nxt = acc_r + delta;
        OP_ADD:  acc_nxt = {acc_r[ACCUMULATOR_BITS-1:ELEM_BITS], sum};
        default: acc_nxt = acc_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

// ===== sv/vfmac_merge.sv =====
`timescale 1ns / 1ps
// merge stage: saturates lane accumulators and packs them into the output register;
// for OP_ADD it packs zeros; depends on vfmac_pkg
module vfmac_merge #(
  parameter int LANE_COUNT       = vfmac_pkg::LANE_COUNT_DEF,
  parameter int ACCUMULATOR_BITS = vfmac_pkg::ACC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  vfmac_pkg::ctl_t             ctl,
  input  logic [ACCUMULATOR_BITS-1:0] lane_acc [LANE_COUNT],
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic [63:0]                 out_result_lo,
  output logic [63:0]                 out_result_hi
);
  import vfmac_pkg::*;

  elem_t       res_elem [PACK_LANES];
  logic [63:0] lo_nxt;
  logic [63:0] hi_nxt;
  logic        valid_r;
  logic        valid_nxt;
  logic [63:0] lo_r;
  logic [63:0] hi_r;

  genvar k;
  generate
    for (k = 0; k < PACK_LANES; k++) begin : g_sat
      if (k < LANE_COUNT) begin : g_live
        logic [ACCUMULATOR_BITS-32:0] upper;
        assign upper = lane_acc[k][ACCUMULATOR_BITS-1:31];
        always_comb begin
          if (ctl.op == OP_ADD) begin
            res_elem[k] = '0;
          end else if ((&upper) || !(|upper)) begin
            res_elem[k] = lane_acc[k][31:16];
          end else if (lane_acc[k][ACCUMULATOR_BITS-1]) begin
            res_elem[k] = SAT_MIN;
          end else begin
            res_elem[k] = SAT_MAX;
          end
        end
      end else begin : g_absent
        assign res_elem[k] = '0;
      end
    end

    for (k = 0; k < PACK_LANES / 2; k++) begin : g_pack
      assign lo_nxt[ELEM_BITS*k +: ELEM_BITS] = res_elem[k];
      assign hi_nxt[ELEM_BITS*k +: ELEM_BITS] = res_elem[k + PACK_LANES / 2];
    end
  endgenerate

  assign valid_nxt = ctl.load | (valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
  end

  assign out_valid     = valid_r;
  assign out_result_lo = lo_r;
  assign out_result_hi = hi_r;

endmodule
